@@ sv/mbe_pkg.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape-time package
// Shared widths, formats, state encoding and the command and status structs
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package mbe_pkg;

	// Port field widths.
	localparam int IN_W   = 32;
	localparam int CNT_W  = 16;

	// Internal fixed-point format of c and z.
	localparam int COORD_BITS = 32;
	localparam int FRAC_BITS  = 28;

	// Exact products carry twice the coordinate width.
	localparam int PROD_W = 2 * COORD_BITS;

	// Rescaled value plus c, wide enough to never wrap.
	localparam int SUM_W = PROD_W + 2;

	// |z|^2 reaches 4 when any bit at or above this position is set.
	localparam int FOUR_SHIFT = 2 * FRAC_BITS + 2;

	// Iteration limit after reset.
	localparam logic [CNT_W-1:0] MAX_ITER_RESET = CNT_W'(255);

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_EVAL,
		ST_DONE
	} mbe_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic mul;
		logic eval;
	} mbe_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic at_max;
		logic escape;
		logic ovf;
	} mbe_stat_t;

endpackage

@@ sv/mandelbrot_escape_time.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape-time unit
// Iterates z = z*z + c from z = 0 and reports how many iterations ran
// before |z|^2 reached 4, z left the coordinate range, or the limit hit.
// ----------------------------------------------------------------------------
// Usage:
// Drive c_real and c_imag (signed, 28 fraction bits) and raise start while
// busy is low; the item is taken at that clock edge. busy stays high until
// the result has been delivered. The result appears on iter_count for
// exactly one cycle with done high; the receiver cannot stall it.
// Each iteration has a multiply step for the three 32x32 products of z
// and an evaluate step for the escape test and the rescaled update of z.
// The next item is taken only once the unit is back in idle after the
// done cycle, so the unit works on one point at a time.
// The limit is written through cfg_we and cfg_wdata while the unit is idle.
// Reset returns the unit to idle and sets the limit to 255.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic signed [mbe_pkg::IN_W-1:0]  c_real,
	input  logic signed [mbe_pkg::IN_W-1:0]  c_imag,
	output logic                             done,
	output logic [mbe_pkg::CNT_W-1:0]        iter_count,
	input  logic                             cfg_we,
	input  logic [mbe_pkg::CNT_W-1:0]        cfg_wdata
);
	import mbe_pkg::*;

	mbe_cmd_t  cmd;
	mbe_stat_t stat;

	// Sequencer.
	mbe_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Arithmetic and point state.
	mbe_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.c_real     (c_real),
		.c_imag     (c_imag),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.iter_count (iter_count)
	);

endmodule

@@ sv/mbe_ctrl.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape-time controller
// Sequences one point through alternating multiply and evaluate steps and
// pulses the result strobe when the point has finished.
// ----------------------------------------------------------------------------
module mbe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  mbe_pkg::mbe_stat_t stat,
	output mbe_pkg::mbe_cmd_t  cmd,
	output logic              busy,
	output logic              done
);
	import mbe_pkg::*;

	mbe_state_t state_q;
	mbe_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.mul  = 1'b0;
		cmd.eval = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				// Stop before multiplying once the limit is reached.
				if (stat.at_max) begin
					state_d = ST_DONE;
				end else begin
					cmd.mul = 1'b1;
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				if (stat.escape || stat.ovf) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_MUL;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

endmodule

@@ sv/mbe_datapath.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape-time datapath
// Holds c, z, the iteration count and the limit register. One step forms
// the exact squares and cross product; the next tests |z|^2 against 4 and
// builds the new z with floor rescaling and a range check.
// ----------------------------------------------------------------------------
module mbe_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mbe_pkg::mbe_cmd_t             cmd,
	output mbe_pkg::mbe_stat_t            stat,
	input  logic signed [mbe_pkg::IN_W-1:0]  c_real,
	input  logic signed [mbe_pkg::IN_W-1:0]  c_imag,
	input  logic                         cfg_we,
	input  logic [mbe_pkg::CNT_W-1:0]     cfg_wdata,
	output logic [mbe_pkg::CNT_W-1:0]     iter_count
);
	import mbe_pkg::*;

	logic [CNT_W-1:0]             max_iter_q;
	logic [CNT_W-1:0]             count_q;
	logic signed [COORD_BITS-1:0] cr_q;
	logic signed [COORD_BITS-1:0] ci_q;
	logic signed [COORD_BITS-1:0] zr_q;
	logic signed [COORD_BITS-1:0] zi_q;

	logic signed [PROD_W-1:0] sq_re_s1;
	logic signed [PROD_W-1:0] sq_im_s1;
	logic signed [PROD_W-1:0] cross_s1;
	logic signed [PROD_W-1:0] sq_re_d;
	logic signed [PROD_W-1:0] sq_im_d;
	logic signed [PROD_W-1:0] cross_d;

	logic [PROD_W:0]          mag_sum;
	logic signed [PROD_W:0]   diff_w;
	logic signed [PROD_W:0]   cross2_w;
	logic signed [PROD_W:0]   re_scaled;
	logic signed [PROD_W:0]   im_scaled;
	logic [SUM_W-1:0]         re_sum;
	logic [SUM_W-1:0]         im_sum;
	logic                     re_fits;
	logic                     im_fits;

	// Limit register, to be written by the user only while the block is idle; the block leaves this unchecked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= MAX_ITER_RESET;
		end else if (cfg_we) begin
			max_iter_q <= cfg_wdata;
		end
	end

	// Exact signed products of the current z.
	always_comb begin
		sq_re_d = PROD_W'(zr_q) * PROD_W'(zr_q);
		sq_im_d = PROD_W'(zi_q) * PROD_W'(zi_q);
		cross_d = PROD_W'(zr_q) * PROD_W'(zi_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			sq_re_s1 <= sq_re_d;
			sq_im_s1 <= sq_im_d;
			cross_s1 <= cross_d;
		end
	end

	// Escape test and new z from the registered products.
	always_comb begin
		mag_sum   = {1'b0, sq_re_s1} + {1'b0, sq_im_s1};
		diff_w    = {sq_re_s1[PROD_W-1], sq_re_s1} - {sq_im_s1[PROD_W-1], sq_im_s1};
		cross2_w  = {cross_s1, 1'b0};
		re_scaled = diff_w >>> FRAC_BITS;
		im_scaled = cross2_w >>> FRAC_BITS;
		re_sum    = {re_scaled[PROD_W], re_scaled}
		          + {{(SUM_W-COORD_BITS){cr_q[COORD_BITS-1]}}, cr_q};
		im_sum    = {im_scaled[PROD_W], im_scaled}
		          + {{(SUM_W-COORD_BITS){ci_q[COORD_BITS-1]}}, ci_q};
		re_fits   = (&re_sum[SUM_W-1:COORD_BITS-1]) || (~|re_sum[SUM_W-1:COORD_BITS-1]);
		im_fits   = (&im_sum[SUM_W-1:COORD_BITS-1]) || (~|im_sum[SUM_W-1:COORD_BITS-1]);
	end

	assign stat.escape = ((mag_sum >> FOUR_SHIFT) != '0);
	assign stat.ovf    = !(re_fits && im_fits);
	assign stat.at_max = (count_q == max_iter_q);

	// Point state: c, z and the count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.load) begin
			count_q <= '0;
		end else if (cmd.eval && !stat.escape) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cr_q <= COORD_BITS'(c_real);
			ci_q <= COORD_BITS'(c_imag);
			zr_q <= '0;
			zi_q <= '0;
		end else if (cmd.eval && !stat.escape && !stat.ovf) begin
			zr_q <= re_sum[COORD_BITS-1:0];
			zi_q <= im_sum[COORD_BITS-1:0];
		end
	end

	assign iter_count = count_q;

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape-time unit testbench
// Sends points through the start/busy handshake and compares every done
// strobe with a typed count or a fixed-point escape-time predictor in the bench.
// A directed table covers the extremes and the known orbits, then random
// points are sent under several iteration limits, the extremes among them.
// ----------------------------------------------------------------------------
module tb;

	import mbe_pkg::*;

	localparam int WIDE_W = SUM_W;
	localparam int ONE    = 1 << FRAC_BITS;
	localparam logic signed [IN_W-1:0] C_MIN = {1'b1, {(IN_W-1){1'b0}}};
	localparam logic signed [IN_W-1:0] C_MAX = {1'b0, {(IN_W-1){1'b1}}};

	// One row of the directed table: the limit to run under, the point, and
	// the count where it is obvious from the orbit.
	typedef struct packed {
		logic [CNT_W-1:0]       limit;
		logic signed [IN_W-1:0] c_re;
		logic signed [IN_W-1:0] c_im;
		logic                   known;
		logic [CNT_W-1:0]       count;
	} point_row_t;

	localparam int N_ROWS = 22;
	localparam point_row_t POINT_ROWS [N_ROWS] = '{
		'{16'd255,   32'sd0,          32'sd0,        1'b1, 16'd255},
		'{16'd255,   C_MIN,           C_MIN,         1'b1, 16'd1},
		'{16'd255,   C_MAX,           C_MAX,         1'b1, 16'd1},
		'{16'd255,   C_MAX,           C_MIN,         1'b1, 16'd1},
		'{16'd255,   2 * ONE,         32'sd0,        1'b1, 16'd1},
		'{16'd255,   -2 * ONE,        32'sd0,        1'b1, 16'd1},
		'{16'd255,   -ONE,            32'sd0,        1'b1, 16'd255},
		'{16'd255,   32'sd0,          ONE,           1'b1, 16'd255},
		'{16'd255,   32'sd0,          -ONE,          1'b0, 16'd0},
		'{16'd255,   ONE / 4,         32'sd0,        1'b0, 16'd0},
		'{16'd255,   ONE / 4 + ONE / 100, 32'sd0,    1'b0, 16'd0},
		'{16'd255,   -3 * ONE / 4,    ONE / 10,      1'b0, 16'd0},
		'{16'd255,   3 * ONE / 10,    ONE / 2,       1'b0, 16'd0},
		'{16'd255,   32'sd1,          -32'sd1,       1'b0, 16'd0},
		'{16'd0,     32'sd0,          32'sd0,        1'b1, 16'd0},
		'{16'd0,     C_MAX,           C_MAX,         1'b1, 16'd0},
		'{16'd1,     32'sd0,          32'sd0,        1'b1, 16'd1},
		'{16'd1,     C_MIN,           C_MIN,         1'b1, 16'd1},
		'{16'd2,     ONE / 2,         ONE / 2,       1'b0, 16'd0},
		'{16'd65535, 32'sd0,          32'sd0,        1'b1, 16'd65535},
		'{16'd65535, -2 * ONE,        32'sd0,        1'b1, 16'd1},
		'{16'd65535, ONE,             32'sd0,        1'b1, 16'd2}
	};

	// Random phases: the limit in force and how many points to send under it.
	localparam int N_PHASES = 9;
	localparam int PHASE_LIMIT [N_PHASES] = '{255, 1, 0, 7, 40, 65535, 1000, 3, 255};
	localparam int PHASE_ITEMS [N_PHASES] = '{150, 60, 30, 150, 200, 6, 50, 54, 150};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic                   busy;
	logic signed [IN_W-1:0] c_real = '0;
	logic signed [IN_W-1:0] c_imag = '0;
	logic                   done;
	logic [CNT_W-1:0]       iter_count;
	logic                   cfg_we = 1'b0;
	logic [CNT_W-1:0]       cfg_wdata = '0;

	logic [CNT_W-1:0] escape_q [$];
	logic [CNT_W-1:0] want_count;
	logic [CNT_W-1:0] cur_limit = MAX_ITER_RESET;
	int               mismatches = 0;
	int               points_sent = 0;
	int               counts_checked = 0;
	int               limit_writes = 0;
	int               burst_left = 0;

	mandelbrot_escape_time dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.c_real     (c_real),
		.c_imag     (c_imag),
		.done       (done),
		.iter_count (iter_count),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Escape-time count of one point under the given limit. z is carried
	// wide so that squares, sums and range checks are exact.
	function automatic logic [CNT_W-1:0] escape_iterations(
		input logic signed [IN_W-1:0] cr,
		input logic signed [IN_W-1:0] ci,
		input logic [CNT_W-1:0]       lim
	);
		logic signed [WIDE_W-1:0] zr, zi, sq_r, sq_i, nr, ni, top_r, top_i;
		int n;
		zr = '0;
		zi = '0;
		n = 0;
		while (n < lim) begin
			sq_r = zr * zr;
			sq_i = zi * zi;
			if (((sq_r + sq_i) >>> FOUR_SHIFT) != 0)
				break;
			n++;
			// Arithmetic shift gives the floor of the rescaled products.
			nr = ((sq_r - sq_i) >>> FRAC_BITS) + cr;
			ni = ((2 * zr * zi) >>> FRAC_BITS) + ci;
			// A part outside the coordinate range ends the point at once.
			top_r = nr >>> (COORD_BITS - 1);
			top_i = ni >>> (COORD_BITS - 1);
			if ((top_r != 0 && top_r != -1) || (top_i != 0 && top_i != -1))
				break;
			zr = nr;
			zi = ni;
		end
		return CNT_W'(n);
	endfunction

	// Send one point after a random gap and queue its expected count.
	task automatic issue_point(
		input logic signed [IN_W-1:0] cr,
		input logic signed [IN_W-1:0] ci,
		input logic                   known,
		input logic [CNT_W-1:0]       typed_count
	);
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			gap = 0;
		end else if ($urandom_range(0, 19) == 0) begin
			burst_left = $urandom_range(5, 30);
			gap = 0;
		end else begin
			gap = $urandom_range(0, 14);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		c_real <= cr;
		c_imag <= ci;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		escape_q.push_back(known ? typed_count : escape_iterations(cr, ci, cur_limit));
		points_sent++;
	endtask

	// Wait until every queued count has come back and the unit is idle.
	task automatic drain();
		start <= 1'b0;
		while (escape_q.size() != 0) @(posedge clk);
		while (busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Change the iteration limit while nothing is in flight.
	task automatic set_limit(input logic [CNT_W-1:0] lim);
		drain();
		cfg_wdata <= lim;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_limit = lim;
		limit_writes++;
	endtask

	// Random point: mostly inside the interesting window, some hugging the
	// set's edge, and the rest anywhere in the full coordinate range.
	task automatic rand_point(
		output logic signed [IN_W-1:0] cr,
		output logic signed [IN_W-1:0] ci
	);
		case ($urandom_range(0, 9))
			0, 1: begin
				cr = $urandom;
				ci = $urandom;
			end
			8: begin
				cr = -3 * ONE / 4 + int'($urandom_range(0, 1 << 21)) - (1 << 20);
				ci = int'($urandom_range(0, 1 << 22)) - (1 << 21);
			end
			9: begin
				cr = ONE / 4 + int'($urandom_range(0, 1 << 21)) - (1 << 20);
				ci = int'($urandom_range(0, 1 << 22)) - (1 << 21);
			end
			default: begin
				cr = int'($urandom_range(0, 3 * ONE)) - 2 * ONE;
				ci = int'($urandom_range(0, 5 * ONE / 2)) - 5 * ONE / 4;
			end
		endcase
	endtask

	// Compare each done strobe with the oldest expected count.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (escape_q.size() == 0) begin
				mismatches++;
				$error("iter_count: result with no point pending, actual %0d", iter_count);
			end else begin
				want_count = escape_q.pop_front();
				counts_checked++;
				if (iter_count !== want_count) begin
					mismatches++;
					$error("iter_count mismatch: expected %0d, actual %0d",
						want_count, iter_count);
				end
			end
		end
	end

	// Main sequence: reset, directed table, random phases, final report.
	initial begin
		logic signed [IN_W-1:0] cr, ci;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < N_ROWS; r++) begin
			if (POINT_ROWS[r].limit != cur_limit)
				set_limit(POINT_ROWS[r].limit);
			issue_point(POINT_ROWS[r].c_re, POINT_ROWS[r].c_im,
				POINT_ROWS[r].known, POINT_ROWS[r].count);
		end

		for (int p = 0; p < N_PHASES; p++) begin
			if (PHASE_LIMIT[p] != cur_limit)
				set_limit(CNT_W'(PHASE_LIMIT[p]));
			for (int i = 0; i < PHASE_ITEMS[p]; i++) begin
				rand_point(cr, ci);
				issue_point(cr, ci, 1'b0, '0);
			end
		end

		drain();
		$display("Sent %0d points under %0d limit changes; %0d counts checked.",
			points_sent, limit_writes, counts_checked);
		$display("Limits ran from 0 to 65535, with %0d mismatches.", mismatches);
		if (mismatches == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

	// Watchdog well beyond the slowest legal run.
	initial begin
		#300000000;
		$display("tb failed");
		$finish;
	end

endmodule

@@ sim.f @@
sv/mbe_pkg.sv
sv/mbe_ctrl.sv
sv/mbe_datapath.sv
sv/mandelbrot_escape_time.sv
tb/tb.sv
